// ----- design/hks_pkg.sv -----
// Shared types, constants and helpers for the hashed key set.
package hks_pkg;

    localparam int MaxEntriesDef  = 256;
    localparam int BucketCountDef = 512;
    localparam int TailKeepDef    = 256;

    localparam logic [63:0] FnvBasis = 64'hCBF29CE484222325;
    localparam logic [63:0] FnvPrime = 64'h00000100000001B3;

    typedef enum logic [1:0] {
        OP_MARK  = 2'd0,
        OP_QUERY = 2'd1,
        OP_CLEAR = 2'd2,
        OP_RESET = 2'd3
    } t_opcode;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] key_byte;
    } t_in_item;

    typedef struct packed {
        logic       found;
        logic [8:0] entry_count;
    } t_out_item;

endpackage

// ----- design/hks_hash_mul.sv -----
// Iterative 64-bit multiplier: one 16x16 partial product per cycle.
module hks_hash_mul
    import hks_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_a,
    input  logic [63:0] i_b,
    output logic        o_done,
    output logic [63:0] o_p
);

    logic [63:0] r_a, r_b, r_acc;
    logic [3:0]  r_step;
    logic        r_busy, r_done;
    logic [1:0]  w_ia, w_ib;
    logic [31:0] w_pp;
    logic [6:0]  w_sh;
    logic [63:0] w_term;

    // select limbs; only pairs with ia+ib<4 reach the low 64 bits
    assign w_ia   = r_step[3:2];
    assign w_ib   = r_step[1:0];
    assign w_pp   = r_a[{w_ia, 4'd0} +: 16] * r_b[{w_ib, 4'd0} +: 16];
    assign w_sh   = {({1'b0, w_ia} + {1'b0, w_ib}), 4'd0};
    assign w_term = ({2'b0, w_ia} + {2'b0, w_ib} < 4'd4) ? ({32'd0, w_pp} << w_sh) : 64'd0;

    // step through all sixteen limb pairs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
                r_a    <= i_a;
                r_b    <= i_b;
                r_acc  <= '0;
            end else if (r_busy) begin
                r_acc  <= r_acc + w_term;
                r_step <= r_step + 4'd1;
                if (r_step == 4'd15) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_p    = r_acc;

endmodule

// ----- design/hashed_key_set_with_oldest_eviction_unit.sv -----
// Top level of the hashed key set with oldest-first eviction.
//
//  channel | direction | payload    | handshake
//  in      | input     | t_in_item  | i_in_valid / o_in_stall
//  out     | output    | t_out_item | o_out_valid / i_out_stall
//
// A key byte is taken in idle and starts the iterative multiplier, which
// forms 16 partial products; S_HASH takes the product and the unit returns
// to idle before the next request is accepted. A terminator walks the bucket
// chain with a read and a compare state per entry and compares stored tail
// bytes likewise, per byte; an insert copies the tail with a read and a
// write state per byte, and a mark on a full table scans all entries for the
// oldest order, reading and comparing each. Reset table and power-on reset
// clear the bucket heads, one per cycle (BUCKET_COUNT of them, a power of
// two); entries carry valid bits. Input stalls until the result is taken.
module hashed_key_set_with_oldest_eviction_unit
    import hks_pkg::*;
#(
    parameter int MAX_ENTRIES  = MaxEntriesDef,
    parameter int BUCKET_COUNT = BucketCountDef,
    parameter int TAIL_KEEP    = TailKeepDef
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    localparam int EW = $clog2(MAX_ENTRIES);
    localparam int LW = $clog2(MAX_ENTRIES + 1);
    localparam int BW = $clog2(BUCKET_COUNT);
    localparam int WL = TAIL_KEEP - 1;
    localparam int WW = $clog2(WL + 1);
    localparam int TW = $clog2(MAX_ENTRIES * WL);

    typedef enum logic [4:0] {
        S_IDLE, S_HASH, S_CLR, S_HEAD_RD, S_HEAD_WT, S_ENT_RD, S_ENT_WT, S_ENT_CMP,
        S_TAIL_RD, S_TAIL_WT, S_TAIL_CMP, S_DECIDE, S_SCAN, S_SCAN_WT, S_SCAN_CMP,
        S_UNL_HD, S_UNL_HWT, S_UNL_WALK, S_UNL_WT, S_ADD, S_COPY, S_OUT
    } t_state;

    t_state r_state;

    // entry memories (hash, length, order, link) and valid bits
    logic [63:0]   m_hash [MAX_ENTRIES];
    logic [31:0]   m_len  [MAX_ENTRIES];
    logic [31:0]   m_ord  [MAX_ENTRIES];
    logic [LW-1:0] m_link [MAX_ENTRIES];
    logic [LW-1:0] m_head [BUCKET_COUNT];
    logic [7:0]    m_tail [MAX_ENTRIES * WL];
    logic [MAX_ENTRIES-1:0] r_used;

    logic [63:0]   r_rd_hash;
    logic [31:0]   r_rd_len, r_rd_ord;
    logic [LW-1:0] r_rd_link, r_rd_head;
    logic [7:0]    r_rd_tail;
    logic [7:0]    r_rd_win;

    // window of recent bytes
    logic [7:0]    r_win [WL];
    logic [WW-1:0] r_wpos;
    logic [63:0]   r_hash;
    logic [31:0]   r_len;
    logic [LW:0]   r_total;
    logic [31:0]   r_ocnt;

    logic [1:0]    r_op;
    logic [LW-1:0] r_slot;
    logic [LW:0]   r_steps;
    logic [WW-1:0] r_i, r_keep;
    logic [EW-1:0] r_idx, r_scan, r_old;
    logic [31:0]   r_old_ord;
    logic          r_found;
    logic [LW-1:0] r_prev;      // 0 means head
    logic [BW:0]   r_clr;
    logic          r_after_unl; // unlink was for eviction
    logic          r_mul_start;
    logic          r_out_found;

    logic          w_mul_done;
    logic [63:0]   w_mul_p;
    logic [BW-1:0] w_bkt;
    logic [WW:0]   w_wi;
    logic [WW-1:0] w_widx;
    logic [EW-1:0] w_free;
    logic          w_any_free;
    logic [TW-1:0] w_tbase;

    hks_hash_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_mul_start),
        .i_a     (r_hash),
        .i_b     (FnvPrime),
        .o_done  (w_mul_done),
        .o_p     (w_mul_p)
    );

    // bucket count is a power of two, so the low hash bits pick the bucket
    assign w_bkt   = r_hash[BW-1:0];
    // window slot (wpos - keep + i) mod WL
    assign w_wi    = {1'b0, r_wpos} + (WW+1)'(WL) - {1'b0, r_keep} + {1'b0, r_i};
    assign w_widx  = (w_wi >= (WW+1)'(WL)) ? WW'(w_wi - (WW+1)'(WL)) : WW'(w_wi);
    assign w_tbase = TW'(r_idx) * TW'(WL) + TW'(r_i);

    // lowest free entry
    always_comb begin
        w_free = '0;
        w_any_free = 1'b0;
        for (int k = MAX_ENTRIES - 1; k >= 0; k--) begin
            if (!r_used[k]) begin
                w_free = EW'(k);
                w_any_free = 1'b1;
            end
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = (r_state == S_OUT);
    assign o_out_data.found       = r_out_found;
    assign o_out_data.entry_count = 9'(r_total);

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_clr <= '0;
            r_used <= '0;
            r_total <= '0;
            r_ocnt <= '0;
            r_hash <= FnvBasis;
            r_len <= '0;
            r_wpos <= '0;
            r_mul_start <= 1'b0;
            r_out_found <= 1'b0;
            // power-on clear returns to idle without a result
            r_op <= OP_QUERY;
        end else begin
            r_mul_start <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        if (i_in_data.key_byte != 8'd0) begin
                            r_hash <= r_hash ^ {56'd0, i_in_data.key_byte};
                            r_win[r_wpos] <= i_in_data.key_byte;
                            r_wpos <= (r_wpos == WW'(WL - 1)) ? '0 : r_wpos + 1'b1;
                            r_len <= r_len + 32'd1;
                            r_mul_start <= 1'b1;
                            r_state <= S_HASH;
                        end else begin
                            r_op <= i_in_data.opcode;
                            r_keep <= (r_len < 32'(WL)) ? WW'(r_len) : WW'(WL);
                            r_found <= 1'b0;
                            if (i_in_data.opcode == OP_RESET) begin
                                r_used <= '0;
                                r_total <= '0;
                                r_ocnt <= '0;
                                r_clr <= '0;
                                r_state <= S_CLR;
                            end else if (r_len == 32'd0) begin
                                r_out_found <= 1'b0;
                                r_state <= S_OUT;
                            end else begin
                                r_state <= S_HEAD_RD;
                            end
                        end
                    end
                end
                S_HASH: if (w_mul_done) begin
                    r_hash <= w_mul_p;
                    r_state <= S_IDLE;
                end
                S_CLR: begin
                    m_head[r_clr[BW-1:0]] <= '0;
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == (BW+1)'(BUCKET_COUNT - 1)) begin
                        r_out_found <= 1'b0;
                        r_state <= (r_op == OP_RESET) ? S_OUT : S_IDLE;
                        if (r_op != OP_RESET) begin
                            r_hash <= FnvBasis;
                            r_len <= '0;
                            r_wpos <= '0;
                        end
                    end
                end
                S_HEAD_RD: begin
                    r_rd_head <= m_head[w_bkt];
                    r_steps <= '0;
                    r_state <= S_HEAD_WT;
                end
                S_HEAD_WT: begin
                    r_slot <= r_rd_head;
                    r_state <= S_ENT_RD;
                end
                S_ENT_RD: begin
                    if (r_slot == '0 || r_slot > LW'(MAX_ENTRIES)
                        || r_steps >= (LW+1)'(MAX_ENTRIES)) begin
                        r_state <= S_DECIDE;
                    end else begin
                        r_idx <= EW'(r_slot - 1'b1);
                        r_rd_hash <= m_hash[EW'(r_slot - 1'b1)];
                        r_rd_len  <= m_len[EW'(r_slot - 1'b1)];
                        r_rd_link <= m_link[EW'(r_slot - 1'b1)];
                        r_state <= S_ENT_CMP;
                    end
                end
                S_ENT_CMP: begin
                    if (r_rd_hash == r_hash && r_rd_len == r_len) begin
                        r_i <= '0;
                        r_state <= S_TAIL_RD;
                    end else begin
                        r_slot <= r_rd_link;
                        r_steps <= r_steps + 1'b1;
                        r_state <= S_ENT_RD;
                    end
                end
                S_TAIL_RD: begin
                    if (r_i == r_keep) begin
                        r_found <= 1'b1;
                        r_state <= S_DECIDE;
                    end else begin
                        r_rd_tail <= m_tail[w_tbase];
                        r_rd_win  <= r_win[w_widx];
                        r_state <= S_TAIL_CMP;
                    end
                end
                S_TAIL_CMP: begin
                    if (r_rd_tail == r_rd_win) begin
                        r_i <= r_i + 1'b1;
                        r_state <= S_TAIL_RD;
                    end else begin
                        r_slot <= r_rd_link;
                        r_steps <= r_steps + 1'b1;
                        r_state <= S_ENT_RD;
                    end
                end
                S_DECIDE: begin
                    if (r_op == OP_MARK && !r_found) begin
                        if (w_any_free) begin
                            r_idx <= w_free;
                            r_state <= S_ADD;
                        end else begin
                            r_scan <= '0;
                            r_old <= '0;
                            r_old_ord <= m_ord[0];
                            r_state <= S_SCAN;
                        end
                    end else if (r_op == OP_CLEAR && r_found) begin
                        r_after_unl <= 1'b0;
                        r_state <= S_UNL_HD;
                    end else begin
                        r_out_found <= r_found;
                        r_state <= S_OUT;
                    end
                end
                S_SCAN: begin
                    r_rd_ord <= m_ord[r_scan];
                    r_state <= S_SCAN_CMP;
                end
                S_SCAN_CMP: begin
                    if (r_rd_ord < r_old_ord) begin
                        r_old <= r_scan;
                        r_old_ord <= r_rd_ord;
                    end
                    if (r_scan == EW'(MAX_ENTRIES - 1)) begin
                        r_idx <= (r_rd_ord < r_old_ord) ? r_scan : r_old;
                        r_after_unl <= 1'b1;
                        r_state <= S_UNL_HD;
                    end else begin
                        r_scan <= r_scan + 1'b1;
                        r_state <= S_SCAN;
                    end
                end
                S_UNL_HD: begin
                    r_rd_hash <= m_hash[r_idx];
                    r_rd_link <= m_link[r_idx];
                    r_state <= S_UNL_HWT;
                end
                S_UNL_HWT: begin
                    r_rd_head <= m_head[r_rd_hash[BW-1:0]];
                    r_prev <= '0;
                    r_steps <= '0;
                    r_state <= S_UNL_WT;
                end
                S_UNL_WT: begin
                    r_slot <= r_rd_head;
                    r_state <= S_UNL_WALK;
                end
                S_UNL_WALK: begin
                    if (r_slot == '0 || r_slot > LW'(MAX_ENTRIES)
                        || r_steps >= (LW+1)'(MAX_ENTRIES) || r_slot == LW'(r_idx) + 1'b1) begin
                        if (r_slot == LW'(r_idx) + 1'b1 && r_slot <= LW'(MAX_ENTRIES)
                            && r_steps < (LW+1)'(MAX_ENTRIES)) begin
                            if (r_prev == '0)
                                m_head[r_rd_hash[BW-1:0]] <= r_rd_link;
                            else
                                m_link[EW'(r_prev - 1'b1)] <= r_rd_link;
                        end else begin
                            m_link[r_idx] <= '0;
                        end
                        r_used[r_idx] <= 1'b0;
                        if (r_total != '0) r_total <= r_total - 1'b1;
                        if (r_after_unl) begin
                            r_state <= S_ADD;
                        end else begin
                            r_out_found <= r_found;
                            r_state <= S_OUT;
                        end
                    end else begin
                        r_prev <= r_slot;
                        r_slot <= m_link[EW'(r_slot - 1'b1)];
                        r_steps <= r_steps + 1'b1;
                    end
                end
                S_ADD: begin
                    m_hash[r_idx] <= r_hash;
                    m_len[r_idx]  <= r_len;
                    m_ord[r_idx]  <= r_ocnt + 32'd1;
                    r_ocnt <= r_ocnt + 32'd1;
                    r_used[r_idx] <= 1'b1;
                    r_rd_head <= m_head[w_bkt];
                    r_i <= '0;
                    r_state <= S_COPY;
                end
                S_COPY: begin
                    if (r_i == r_keep) begin
                        m_link[r_idx] <= r_rd_head;
                        m_head[w_bkt] <= LW'(r_idx) + 1'b1;
                        r_total <= r_total + 1'b1;
                        r_out_found <= 1'b0;
                        r_state <= S_OUT;
                    end else begin
                        r_rd_win <= r_win[w_widx];
                        r_state <= S_TAIL_WT;
                    end
                end
                // write one tail byte, then advance
                S_TAIL_WT: begin
                    m_tail[w_tbase] <= r_rd_win;
                    r_i <= r_i + 1'b1;
                    r_state <= S_COPY;
                end
                S_OUT: if (!i_out_stall) begin
                    r_hash <= FnvBasis;
                    r_len <= '0;
                    r_wpos <= '0;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ----- design/hks_checker.sv -----
// Port-level checker for the hashed key set, bound to the top level.
module hks_checker
    import hks_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input t_in_item  i_in_data,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out_data
);

    // a result holds while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("result changed under stall");

    // no input accepted while a result is pending
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("input taken while result pending");

    // count reported with a result never exceeds 256
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.entry_count <= 9'd256)
        else $error("count out of range");

    // handshake outputs are always known out of reset
    a_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$isunknown({o_out_valid, o_in_stall}))
        else $error("handshake output unknown");

endmodule

bind hashed_key_set_with_oldest_eviction_unit hks_checker u_hks_checker (.*);
